// ===== rtl/skvl_pkg.sv =====
// shared types and constants of the sorted key and row-id leaf table
package skvl_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int KEY_BITS    = 32;
  localparam int PROBE_W     = 32;
  localparam int VAL_W       = 64;
  localparam int CAP_W       = 9;
  localparam int POS_W       = 9;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_LOWER  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } st_e;

  typedef struct packed {
    op_e                operation;
    logic [PROBE_W-1:0] probe_key;
    logic [VAL_W-1:0]   row_value;
  } in_t;

  typedef struct packed {
    st_e              status;
    logic [VAL_W-1:0] found_value;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] entry_count;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rd_mid;
    logic rd_pos;
    logic step;
    logic check;
    logic shift_start;
    logic shift_run;
    logic write_new;
    logic cnt_inc;
    logic cnt_dec;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    op_e  op;
    logic lo_lt_hi;
    logic hit;
    logic full;
    logic shift_done;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/skvl_ram.sv =====
// generic single write port ram with registered read
module skvl_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/skvl_ctrl.sv =====
// sequencing state machine of the leaf table
module skvl_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  skvl_pkg::stat_t stat_i,
  output skvl_pkg::cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SRCH_RD  = 7'b0000010,
    S_SRCH_CMP = 7'b0000100,
    S_CHECK    = 7'b0001000,
    S_SHIFT    = 7'b0010000,
    S_WRITE    = 7'b0100000,
    S_FINISH   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        if (stat_i.lo_lt_hi) begin
          cmd_o.rd_mid = 1'b1;
          state_d      = S_SRCH_CMP;
        end else begin
          // search converged, fetch the entry at the lower bound
          cmd_o.rd_pos = 1'b1;
          state_d      = S_CHECK;
        end
      end
      S_SRCH_CMP: begin
        cmd_o.step = 1'b1;
        state_d    = S_SRCH_RD;
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = S_FINISH;
        if ((stat_i.op == skvl_pkg::OP_INSERT && !stat_i.full) ||
            (stat_i.op == skvl_pkg::OP_REMOVE && stat_i.hit)) begin
          cmd_o.shift_start = 1'b1;
          state_d           = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd_o.shift_run = 1'b1;
        if (stat_i.shift_done) begin
          if (stat_i.op == skvl_pkg::OP_INSERT) begin
            state_d = S_WRITE;
          end else begin
            cmd_o.cnt_dec = 1'b1;
            state_d       = S_FINISH;
          end
        end
      end
      S_WRITE: begin
        cmd_o.write_new = 1'b1;
        cmd_o.cnt_inc   = 1'b1;
        state_d         = S_FINISH;
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/skvl_dp.sv =====
// datapath: search bounds, shift pipeline, count, limit and result register
module skvl_dp #(
  parameter int TABLE_DEPTH = skvl_pkg::TABLE_DEPTH,
  parameter int KEY_BITS    = skvl_pkg::KEY_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  skvl_pkg::in_t                in_data_i,
  input  skvl_pkg::cmd_t               cmd_i,
  output skvl_pkg::stat_t              stat_o,
  input  logic                         cfg_valid_i,
  input  logic [skvl_pkg::CAP_W-1:0]   cfg_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output skvl_pkg::out_t               out_data_o
);

  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int VAL_W  = skvl_pkg::VAL_W;
  localparam int CAP_W  = skvl_pkg::CAP_W;
  localparam int PW     = skvl_pkg::POS_W;
  localparam int LIM_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int WORD_W = KEY_BITS + VAL_W;

  // control state
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CAP_W-1:0] cap_q;
  logic             out_valid_q;
  logic             pend_q, pend_d;
  logic [CNT_W-1:0] rem_q, rem_d;

  // payload
  skvl_pkg::op_e     op_q;
  logic [KEY_BITS-1:0] key_q;
  logic [VAL_W-1:0]  val_q;
  logic [CNT_W-1:0]  lo_q, lo_d;
  logic [CNT_W-1:0]  hi_q, hi_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic [IDX_W-1:0]  pend_addr_q, pend_addr_d;
  skvl_pkg::st_e     res_st_q;
  logic [VAL_W-1:0]  res_val_q;
  skvl_pkg::out_t    out_q;

  // ram
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic [KEY_BITS-1:0] rd_key;
  logic [VAL_W-1:0]  rd_val;

  logic [CNT_W:0]    mid_sum;
  logic [CNT_W-1:0]  mid;
  logic [CNT_W-1:0]  cnt_m1;
  logic [CNT_W-1:0]  lo_p1;
  logic [LIM_W-1:0]  cap_ext, depth_ext, limit;
  logic              full;
  logic              hit;
  logic              shift_up;

  assign rd_key = ram_rdata[WORD_W-1:VAL_W];
  assign rd_val = ram_rdata[VAL_W-1:0];

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[CNT_W:1];
  assign cnt_m1  = cnt_q - CNT_W'(1);
  assign lo_p1   = lo_q + CNT_W'(1);

  assign cap_ext   = LIM_W'(cap_q);
  assign depth_ext = LIM_W'(TABLE_DEPTH);
  assign limit     = (cap_ext < depth_ext) ? cap_ext : depth_ext;
  assign full      = (LIM_W'(cnt_q) >= limit);
  assign hit       = (lo_q < cnt_q) && (rd_key == key_q);
  assign shift_up  = (op_q == skvl_pkg::OP_INSERT);

  assign stat_o.op         = op_q;
  assign stat_o.lo_lt_hi   = (lo_q < hi_q);
  assign stat_o.hit        = hit;
  assign stat_o.full       = full;
  assign stat_o.shift_done = (rem_q == '0) && !pend_q;
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  // read address
  always_comb begin
    priority if (cmd_i.rd_mid) begin
      ram_raddr = mid[IDX_W-1:0];
    end else if (cmd_i.rd_pos) begin
      ram_raddr = lo_q[IDX_W-1:0];
    end else begin
      ram_raddr = rd_idx_q;
    end
  end

  // write port: new pair at the lower bound, else the pending shifted entry
  assign ram_we    = cmd_i.write_new || (cmd_i.shift_run && pend_q);
  assign ram_waddr = cmd_i.write_new ? lo_q[IDX_W-1:0] : pend_addr_q;
  assign ram_wdata = cmd_i.write_new ? {key_q, val_q} : ram_rdata;

  skvl_ram #(
    .WIDTH(WORD_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // search bounds
  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (cmd_i.load) begin
      lo_d = '0;
      hi_d = cnt_q;
    end else if (cmd_i.step) begin
      if (rd_key < key_q) begin
        lo_d = mid + CNT_W'(1);
      end else begin
        hi_d = mid;
      end
    end
  end

  // shift pipeline: read one entry a cycle, write it one slot over next cycle
  always_comb begin
    rem_d       = rem_q;
    rd_idx_d    = rd_idx_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    if (cmd_i.shift_start) begin
      pend_d = 1'b0;
      if (shift_up) begin
        rem_d    = cnt_q - lo_q;
        rd_idx_d = cnt_m1[IDX_W-1:0];
      end else begin
        rem_d    = cnt_m1 - lo_q;
        rd_idx_d = lo_p1[IDX_W-1:0];
      end
    end else if (cmd_i.shift_run) begin
      pend_d = (rem_q != '0);
      if (rem_q != '0) begin
        rem_d = rem_q - CNT_W'(1);
        if (shift_up) begin
          rd_idx_d    = rd_idx_q - IDX_W'(1);
          pend_addr_d = rd_idx_q + IDX_W'(1);
        end else begin
          rd_idx_d    = rd_idx_q + IDX_W'(1);
          pend_addr_d = rd_idx_q - IDX_W'(1);
        end
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cap_q       <= skvl_pkg::CAP_RESET;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      rem_q       <= '0;
    end else begin
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
      rem_q  <= rem_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    rd_idx_q    <= rd_idx_d;
    pend_addr_q <= pend_addr_d;
    if (cmd_i.load) begin
      op_q  <= in_data_i.operation;
      key_q <= KEY_BITS'(in_data_i.probe_key);
      val_q <= in_data_i.row_value;
    end
    if (cmd_i.check) begin
      res_val_q <= (op_q == skvl_pkg::OP_LOOKUP && hit) ? rd_val : '0;
      unique case (op_q)
        skvl_pkg::OP_LOOKUP: begin
          res_st_q <= hit ? skvl_pkg::ST_OK : skvl_pkg::ST_NOT_FOUND;
        end
        skvl_pkg::OP_INSERT: begin
          res_st_q <= full ? skvl_pkg::ST_FULL : skvl_pkg::ST_OK;
        end
        skvl_pkg::OP_REMOVE: begin
          res_st_q <= hit ? skvl_pkg::ST_OK : skvl_pkg::ST_NOT_FOUND;
        end
        skvl_pkg::OP_LOWER: begin
          res_st_q <= skvl_pkg::ST_OK;
        end
        default: begin
          res_st_q <= skvl_pkg::ST_OK;
        end
      endcase
    end
    if (cmd_i.out_load) begin
      out_q.status      <= res_st_q;
      out_q.found_value <= res_val_q;
      out_q.position    <= PW'(lo_q);
      out_q.entry_count <= PW'(cnt_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/sorted_key_value_leaf_table_top.sv =====
// top level of the sorted key and row-id leaf table
//
//  channel  direction  handshake        payload
//  in       input      valid / stall    skvl_pkg::in_t  (operation, probe_key, row_value)
//  out      output     valid / stall    skvl_pkg::out_t (status, found_value, position,
//                                                        entry_count)
//  cfg      input      valid / ready    capacity_limit, 9 bits, always ready
//
// one request at a time: a load step, then binary search steps over the live entries
// (up to ceil(log2(count+1)) steps, each a read of the midpoint and a compare), then a
// fetch and a check at the lower bound and a step to register the result. a non-full insert
// and a hitting remove also move the entries behind the lower bound one ram slot over, one
// entry a cycle, through the single ram port pair; insert then writes the new pair. no
// clearing pass after reset; the count starts at zero. a waiting result does not block
// the next transfer in; the block only holds its finished result while out is stalled.
module sorted_key_value_leaf_table_top #(
  parameter int TABLE_DEPTH = skvl_pkg::TABLE_DEPTH,
  parameter int KEY_BITS    = skvl_pkg::KEY_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  skvl_pkg::in_t              in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output skvl_pkg::out_t             out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [skvl_pkg::CAP_W-1:0] cfg_data_i
);

  skvl_pkg::cmd_t  cmd;
  skvl_pkg::stat_t stat;
  logic            in_ready;

  assign in_stall_o  = !in_ready;
  assign cfg_ready_o = 1'b1;

  skvl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  skvl_dp #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BITS   (KEY_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .cfg_valid_i(cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

// ===== bench/tb_sorted_key_value_leaf_table_top.sv =====
// self-checking testbench for the sorted key and row-id leaf table
`timescale 1ns / 100ps

module tb_sorted_key_value_leaf_table_top;
  import skvl_pkg::*;

  localparam int IDLE_LIMIT  = 5000;
  localparam int SETTLE_CYC  = 300;
  localparam int POOL_SIZE   = 16;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_t              in_data_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_t             out_data_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CAP_W-1:0] cfg_data_i  = '0;

  sorted_key_value_leaf_table_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0; #2;
    clk_i = 1'b1; #2;
  end

  // predicted table contents, mirrored at every accepted transfer
  logic [KEY_BITS-1:0] table_key [TABLE_DEPTH];
  logic [VAL_W-1:0]    table_val [TABLE_DEPTH];
  int                  table_count = 0;
  logic [CAP_W-1:0]    cap_limit   = CAP_RESET;

  in_t  pending_items[$];
  out_t expected_results[$];

  int   mismatch_count = 0;
  int   op_count[4]    = '{default: 0};
  int   full_count     = 0;
  int   miss_count     = 0;
  int   peak_count     = 0;
  int   cap_writes     = 0;
  logic in_accepted    = 1'b0;

  logic [PROBE_W-1:0] key_pool[POOL_SIZE];
  bit                 keep_top_clear = 1'b0;

  function automatic out_t apply_leaf_op(in_t req);
    out_t                res;
    int                  lo, hi, mid, lim, i;
    logic                hit;
    logic [KEY_BITS-1:0] key;
    key = req.probe_key[KEY_BITS-1:0];
    lo  = 0;
    hi  = table_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (table_key[mid] < key) lo = mid + 1;
      else hi = mid;
    end
    hit = (lo < table_count) && (table_key[lo] == key);
    lim = (int'(cap_limit) < TABLE_DEPTH) ? int'(cap_limit) : TABLE_DEPTH;
    res.status      = ST_OK;
    res.found_value = '0;
    res.position    = POS_W'(lo);
    op_count[req.operation]++;
    case (req.operation)
      OP_LOOKUP: begin
        if (hit) res.found_value = table_val[lo];
        else res.status = ST_NOT_FOUND;
      end
      OP_INSERT: begin
        if (table_count >= lim) begin
          res.status = ST_FULL;
        end else begin
          // new pair lands ahead of any equal keys
          for (i = table_count; i > lo; i--) begin
            table_key[i] = table_key[i-1];
            table_val[i] = table_val[i-1];
          end
          table_key[lo] = key;
          table_val[lo] = req.row_value;
          table_count++;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          for (i = lo; i < table_count - 1; i++) begin
            table_key[i] = table_key[i+1];
            table_val[i] = table_val[i+1];
          end
          table_count--;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      OP_LOWER: ;
    endcase
    if (res.status == ST_FULL) full_count++;
    if (res.status == ST_NOT_FOUND) miss_count++;
    if (table_count > peak_count) peak_count = table_count;
    res.entry_count = POS_W'(table_count);
    return res;
  endfunction

  // result check first, then the new request, so a stray result never meets its own request
  always @(posedge clk_i) begin : monitor
    out_t want;
    if (!rst_ni) begin
      in_accepted <= 1'b0;
    end else begin
      in_accepted <= in_valid_i && !in_stall_o;
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no request outstanding");
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data_o.status);
            mismatch_count++;
          end
          if (out_data_o.found_value !== want.found_value) begin
            $error("found_value: expected %h, got %h", want.found_value,
                   out_data_o.found_value);
            mismatch_count++;
          end
          if (out_data_o.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, out_data_o.position);
            mismatch_count++;
          end
          if (out_data_o.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   out_data_o.entry_count);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        cap_limit = cfg_data_i;
        cap_writes++;
      end
      if (in_valid_i && !in_stall_o) expected_results.push_back(apply_leaf_op(in_data_i));
    end
  end

  // sender: bursts with random gaps, now and then holding off until everything is back
  int burst_left  = 1;
  int gap_left    = 0;
  bit drain_pause = 1'b0;

  always @(negedge clk_i) begin : driver
    int pick;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_accepted) begin
      if (drain_pause) begin
        in_valid_i <= 1'b0;
        if (expected_results.size() == 0) drain_pause <= 1'b0;
      end else if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (pending_items.size() > 0) begin
        in_data_i  <= pending_items.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
          pick = $urandom_range(0, 99);
          if (pick < 20) gap_left <= 0;
          else if (pick < 85) gap_left <= $urandom_range(1, 6);
          else if (pick < 95) gap_left <= $urandom_range(10, 40);
          else drain_pause <= 1'b1;
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: stall style switches every so often
  int       stall_mode = 0;
  int       stall_left = 0;
  bit [2:0] stall_tick = '0;

  always @(negedge clk_i) begin
    stall_tick <= stall_tick + 3'd1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= (stall_tick >= 3'd5);
    endcase
  end

  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results outstanding", IDLE_LIMIT,
               expected_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_drained();
    cfg_data_i  <= cap;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_item(input op_e op, input logic [PROBE_W-1:0] key,
                           input logic [VAL_W-1:0] val);
    in_t item;
    item.operation = op;
    item.probe_key = key;
    item.row_value = val;
    pending_items.push_back(item);
  endtask

  task automatic refresh_pool();
    int i;
    for (i = 0; i < POOL_SIZE; i++)
      key_pool[i] = ($urandom_range(0, 3) == 0) ? PROBE_W'($urandom_range(0, 63)) : $urandom;
    key_pool[0] = '0;
    key_pool[POOL_SIZE-1] = '1;
  endtask

  // mostly pool keys so that lookups and removes hit and duplicates pile up
  task automatic queue_random(input int n, input int w_ins, input int w_rem, input int w_look);
    int                 i, pick;
    op_e                op;
    logic [PROBE_W-1:0] key;
    logic [VAL_W-1:0]   val;
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < w_ins) op = OP_INSERT;
      else if (pick < w_ins + w_rem) op = OP_REMOVE;
      else if (pick < w_ins + w_rem + w_look) op = OP_LOOKUP;
      else op = OP_LOWER;
      pick = $urandom_range(0, 99);
      if (pick < 75) key = key_pool[$urandom_range(0, POOL_SIZE-1)];
      else if (pick < 95) key = $urandom;
      else key = $urandom_range(0, 1) ? '1 : '0;
      // keeps room above every stored key so a probe can land past the last entry
      if (keep_top_clear && op == OP_INSERT) key[PROBE_W-1] = 1'b0;
      pick = $urandom_range(0, 19);
      if (pick == 0) val = '0;
      else if (pick == 1) val = '1;
      else val = {$urandom, $urandom};
      push_item(op, key, val);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty table, then extremes and duplicate keys at the reset capacity
    push_item(OP_LOOKUP, 32'd5, '1);
    push_item(OP_REMOVE, 32'd5, '0);
    push_item(OP_LOWER,  '1, '0);
    push_item(OP_INSERT, '0, '1);
    push_item(OP_INSERT, '1, '0);
    push_item(OP_INSERT, 32'd1000, 64'h0123_4567_89ab_cdef);
    push_item(OP_INSERT, 32'd1000, 64'hfedc_ba98_7654_3210);
    push_item(OP_LOOKUP, 32'd1000, '0);
    push_item(OP_LOWER,  32'd1000, '1);
    push_item(OP_LOWER,  '1, '0);
    push_item(OP_LOWER,  '0, '0);
    push_item(OP_LOOKUP, '1, '0);
    push_item(OP_REMOVE, 32'd1000, '0);
    push_item(OP_LOOKUP, 32'd1000, '0);
    push_item(OP_REMOVE, 32'd7, '0);

    // table at its limit refuses inserts
    write_capacity(9'd3);
    push_item(OP_INSERT, 32'd5, '1);
    push_item(OP_LOWER,  32'd5, '0);

    // zero capacity refuses inserts, removes still work
    write_capacity(9'd0);
    push_item(OP_INSERT, 32'd9, '1);
    push_item(OP_REMOVE, '0, '0);

    // limit below the live count keeps the entries
    write_capacity(9'd1);
    push_item(OP_INSERT, 32'd9, '1);
    push_item(OP_LOOKUP, '0, '0);

    refresh_pool();
    write_capacity(9'd16);
    queue_random(300, 35, 25, 20);

    // fill to the full depth, limit above the depth
    refresh_pool();
    keep_top_clear = 1'b1;
    write_capacity(9'd511);
    queue_random(320, 80, 0, 10);

    write_capacity(9'd256);
    queue_random(300, 15, 60, 12);
    keep_top_clear = 1'b0;

    refresh_pool();
    write_capacity(CAP_W'($urandom_range(0, 511)));
    queue_random(250, 35, 25, 20);

    write_capacity(9'd1);
    queue_random(150, 35, 30, 20);

    refresh_pool();
    write_capacity(CAP_W'($urandom_range(2, 40)));
    queue_random(380, 35, 25, 20);

    wait_drained();
    repeat (SETTLE_CYC) @(negedge clk_i);

    $display("covered %0d lookups, %0d inserts, %0d removes, %0d lower-bound probes",
             op_count[OP_LOOKUP], op_count[OP_INSERT], op_count[OP_REMOVE],
             op_count[OP_LOWER]);
    $display("%0d refused inserts, %0d misses, peak of %0d entries, %0d capacity writes",
             full_count, miss_count, peak_count, cap_writes);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/skvl_pkg.sv
rtl/skvl_ram.sv
rtl/skvl_ctrl.sv
rtl/skvl_dp.sv
rtl/sorted_key_value_leaf_table_top.sv
bench/tb_sorted_key_value_leaf_table_top.sv
